### hw/rtl/hpt_pkg.sv
// Shared types and constants for the HPACK table size tracker.
package hpt_pkg;

	localparam int DEF_CAPACITY = 128;
	localparam logic [31:0] LIMIT_RESET = 32'd4096;

	// command codes
	localparam logic CMD_ALLOC    = 1'b0;
	localparam logic CMD_SET_SIZE = 1'b1;

	typedef struct packed {
		logic        command;
		logic [31:0] amount;
	} cmd_word_t;

	typedef struct packed {
		logic [31:0] entry_index;
		logic        limit_changed;
		logic [7:0]  entries_in_use;
		logic [31:0] bytes_in_use;
	} result_word_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	// operation request to the shared adder
	typedef struct packed {
		alu_op_t     op;
		logic [32:0] a;
		logic [32:0] b;
	} alu_req_t;

endpackage

### hw/rtl/hpt_alu.sv
// Shared 33-bit add/subtract unit; bit 33 of a subtract is the borrow.
module hpt_alu (
	input  hpt_pkg::alu_req_t req,
	output logic [33:0]       y
);
	import hpt_pkg::*;

	always_comb begin
		case (req.op)
			ALU_ADD: y = {1'b0, req.a} + {1'b0, req.b};
			ALU_SUB: y = {1'b0, req.a} - {1'b0, req.b};
			default: y = '0;
		endcase
	end

endmodule

### hw/rtl/hpack_table_size_tracker.sv
// Top level: HPACK dynamic table size tracker with eviction sequencer.
//
//   channel   ports                   handshake
//   --------  ----------------------  -------------------------------------
//   command   start, busy, cmd_word   word taken when start & !busy
//   result    result_strobe, result_  one-cycle strobe, one word per command
//             word
//
// Sequencing: one shared 33-bit adder under a sequencer. Allocate, no eviction:
//   check, fit add and compare, full check, index, reduce, store. An eviction
//   adds a read and a subtract, then re-checks the fit, a full table or a new limit.
//   Oversize allocate evicts all entries; set-size ends at once on an unchanged limit.
// Reset: counters, byte total and index clear, limit 4096; ring left as is.
// Stalls: busy after accept through the strobe cycle; receiver cannot stall.
module hpack_table_size_tracker #(
	parameter int CAPACITY = hpt_pkg::DEF_CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  hpt_pkg::cmd_word_t   cmd_word,
	output logic                 result_strobe,
	output hpt_pkg::result_word_t result_word
);
	import hpt_pkg::*;

	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // ring slot bits
	localparam int CW = $clog2(CAPACITY + 1);                   // entry count bits
	localparam int RW = $clog2(3 * CAPACITY);                   // unreduced slot bits
	// 2^32 mod CAPACITY; an index sum that carries out of 32 bits is
	// corrected by adding CAPACITY minus that, mod CAPACITY
	localparam longint unsigned WRAP_MOD = (64'd1 << 32) % CAPACITY;
	localparam int WRAP_ADJ = int'((CAPACITY - WRAP_MOD) % CAPACITY);

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b0000_0000_0001,
		ST_CHECK    = 12'b0000_0000_0010,
		ST_FIT_ADD  = 12'b0000_0000_0100,
		ST_FIT_CMP  = 12'b0000_0000_1000,
		ST_FULL_CHK = 12'b0000_0001_0000,
		ST_EV_RD    = 12'b0000_0010_0000,
		ST_EV_SUB   = 12'b0000_0100_0000,
		ST_IDX      = 12'b0000_1000_0000,
		ST_REDUCE   = 12'b0001_0000_0000,
		ST_STORE    = 12'b0010_0000_0000,
		ST_SZ_CMP   = 12'b0100_0000_0000,
		ST_DONE     = 12'b1000_0000_0000
	} state_t;

	// which eviction loop is running, so EV_SUB knows where to return
	typedef enum logic [1:0] {
		LOOP_ALL  = 2'd0,
		LOOP_FIT  = 2'd1,
		LOOP_FULL = 2'd2,
		LOOP_SIZE = 2'd3
	} loop_t;

	state_t        state_q;
	loop_t         loop_q;

	// control state
	logic [31:0]   oldest_q;       // running index of last evicted entry
	logic [SW-1:0] oldest_slot_q;  // oldest_q mod CAPACITY
	logic [CW-1:0] count_q;
	logic [31:0]   total_q;
	logic [31:0]   limit_q;

	// per-command payload
	logic          command_q;
	logic [31:0]   amount_q;
	logic [32:0]   sum_q;
	logic [31:0]   index_q;
	logic          changed_q;
	logic [RW-1:0] raw_q;
	logic [15:0]   rd_q;

	logic [15:0]   ring [CAPACITY];

	alu_req_t      alu_req;
	logic [33:0]   alu_y;
	logic          borrow;
	logic [SW-1:0] next_slot;
	logic          count_zero;
	logic [CW+7:0] count_ext;

	hpt_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	assign borrow     = alu_y[33];
	assign count_zero = (count_q == '0);

	// operand select for the shared adder
	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = '0;
		alu_req.b  = '0;
		case (state_q)
			ST_CHECK: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = {1'b0, limit_q};
				alu_req.b  = {1'b0, amount_q};
			end
			ST_FIT_ADD: begin
				alu_req.a = {1'b0, total_q};
				alu_req.b = {1'b0, amount_q};
			end
			ST_FIT_CMP: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = {1'b0, limit_q};
				alu_req.b  = sum_q;
			end
			ST_EV_RD: begin
				alu_req.a = {1'b0, oldest_q};
				alu_req.b = 33'd1;
			end
			ST_EV_SUB: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = {1'b0, total_q};
				alu_req.b  = {17'b0, rd_q};
			end
			ST_IDX: begin
				alu_req.a = {1'b0, oldest_q};
				alu_req.b = 33'(count_q) + 33'd1;
			end
			ST_STORE: begin
				alu_req.a = {1'b0, total_q};
				alu_req.b = {1'b0, amount_q};
			end
			ST_SZ_CMP: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = {1'b0, amount_q};
				alu_req.b  = {1'b0, total_q};
			end
			default: begin
				alu_req.op = ALU_ADD;
			end
		endcase
	end

	// slot of oldest_q + 1; a 32-bit wrap of the index lands on slot 0
	always_comb begin
		if (alu_y[32] || (oldest_slot_q == SW'(CAPACITY - 1)))
			next_slot = '0;
		else
			next_slot = oldest_slot_q + 1'b1;
	end

	// size ring: written on store, read one slot per eviction
	always_ff @(posedge clk) begin
		if (state_q == ST_STORE)
			ring[raw_q[SW-1:0]] <= amount_q[15:0];
		if (state_q == ST_EV_RD)
			rd_q <= ring[next_slot];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			loop_q        <= LOOP_ALL;
			oldest_q      <= '0;
			oldest_slot_q <= '0;
			count_q       <= '0;
			total_q       <= '0;
			limit_q       <= LIMIT_RESET;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (command_q == CMD_ALLOC) begin
						// oversize: above limit or not fitting 16 bits
						if (borrow || (amount_q[31:16] != '0)) begin
							loop_q  <= LOOP_ALL;
							state_q <= ST_EV_RD;
						end else begin
							state_q <= ST_FIT_ADD;
						end
					end else if (alu_y[32:0] == '0) begin
						state_q <= ST_DONE;  // same limit, nothing to do
					end else begin
						state_q <= ST_SZ_CMP;
					end
				end
				ST_FIT_ADD: begin
					state_q <= ST_FIT_CMP;
				end
				ST_FIT_CMP: begin
					if (borrow && !count_zero) begin
						loop_q  <= LOOP_FIT;
						state_q <= ST_EV_RD;
					end else begin
						state_q <= ST_FULL_CHK;
					end
				end
				ST_FULL_CHK: begin
					if (count_q >= CW'(CAPACITY)) begin
						loop_q  <= LOOP_FULL;
						state_q <= ST_EV_RD;
					end else begin
						state_q <= ST_IDX;
					end
				end
				ST_EV_RD: begin
					if (count_zero) begin
						// loop ends on an empty table
						case (loop_q)
							LOOP_ALL: begin
								total_q <= '0;
								state_q <= ST_DONE;
							end
							LOOP_SIZE: begin
								limit_q <= amount_q;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_FULL_CHK;
						endcase
					end else begin
						oldest_q      <= alu_y[31:0];
						oldest_slot_q <= next_slot;
						state_q       <= ST_EV_SUB;
					end
				end
				ST_EV_SUB: begin
					total_q <= borrow ? 32'd0 : alu_y[31:0];
					count_q <= count_q - 1'b1;
					case (loop_q)
						LOOP_ALL:  state_q <= ST_EV_RD;
						LOOP_FIT:  state_q <= ST_FIT_ADD;
						LOOP_FULL: state_q <= ST_IDX;
						default:   state_q <= ST_SZ_CMP;
					endcase
				end
				ST_IDX: begin
					state_q <= ST_REDUCE;
				end
				ST_REDUCE: begin
					if (raw_q < RW'(CAPACITY))
						state_q <= ST_STORE;
				end
				ST_STORE: begin
					total_q <= alu_y[31:0];
					count_q <= count_q + 1'b1;
					state_q <= ST_DONE;
				end
				ST_SZ_CMP: begin
					if (borrow && !count_zero) begin
						loop_q  <= LOOP_SIZE;
						state_q <= ST_EV_RD;
					end else begin
						limit_q <= amount_q;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-command payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					command_q <= cmd_word.command;
					amount_q  <= cmd_word.amount;
				end
			end
			ST_CHECK: begin
				index_q   <= '0;
				changed_q <= (command_q == CMD_SET_SIZE) && (alu_y[32:0] != '0);
			end
			ST_FIT_ADD: begin
				sum_q <= alu_y[32:0];
			end
			ST_IDX: begin
				// slot of oldest + count + 1, reduced below
				index_q <= alu_y[31:0];
				raw_q   <= RW'(oldest_slot_q) + RW'(count_q) + RW'(1)
				           + (alu_y[32] ? RW'(WRAP_ADJ) : RW'(0));
			end
			ST_REDUCE: begin
				if (raw_q >= RW'(CAPACITY))
					raw_q <= raw_q - RW'(CAPACITY);
			end
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

	assign count_ext = {8'b0, count_q};

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = (state_q == ST_DONE);

	assign result_word.entry_index    = index_q;
	assign result_word.limit_changed  = changed_q;
	assign result_word.entries_in_use = count_ext[7:0];
	assign result_word.bytes_in_use   = total_q;

endmodule
